// ===== design/ocr_pkg.sv =====
// ----------------------------------------------------------------------------
// ocr_pkg
// Shared widths, mode codes and controller states for the cell reduction.
// ----------------------------------------------------------------------------
package ocr_pkg;

    localparam int VALUE_W         = 32;
    localparam int RESULT_W        = 36;
    localparam int MODE_W          = 3;
    localparam int MAX_SOURCES_DEF = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_SUM    = 3'd0,
        MODE_MEAN   = 3'd1,
        MODE_MIN    = 3'd2,
        MODE_MAX    = 3'd3,
        MODE_MEDIAN = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_PICK,
        ST_CALC,
        ST_DIV,
        ST_SEND
    } state_t;

endpackage

// ===== design/ocr_if.sv =====
// ----------------------------------------------------------------------------
// ocr_if
// Valid/ready channels for input words, result words and the mode register.
// ----------------------------------------------------------------------------
interface ocr_in_if;
    import ocr_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] sample_value;
    logic                      sample_present;
    logic                      cell_last;

    modport source (output valid, sample_value, sample_present, cell_last, input ready);
    modport sink   (input valid, sample_value, sample_present, cell_last, output ready);
endinterface

interface ocr_out_if;
    import ocr_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [RESULT_W-1:0] cell_result;
    logic                       result_valid;
    logic                       capacity_overflow;

    modport source (output valid, cell_result, result_valid, capacity_overflow,
                    input ready);
    modport sink   (input valid, cell_result, result_valid, capacity_overflow,
                    output ready);
endinterface

interface ocr_cfg_if;
    import ocr_pkg::*;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] reduce_mode;

    modport source (output valid, reduce_mode, input ready);
    modport sink   (input valid, reduce_mode, output ready);
endinterface

// ===== design/ocr_cell.sv =====
// ----------------------------------------------------------------------------
// ocr_cell
// One slot of the sorted value row; takes its left neighbor's value on insert.
// ----------------------------------------------------------------------------
module ocr_cell
    import ocr_pkg::*;
(
    input  logic                      clk,
    input  logic                      insert,
    input  logic signed [VALUE_W-1:0] in_value,
    input  logic signed [VALUE_W-1:0] prev_value,
    input  logic                      prev_greater,
    input  logic                      occupied,
    input  logic                      at_end,
    output logic signed [VALUE_W-1:0] value,
    output logic                      greater
);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;

    assign greater = occupied && (value_reg > in_value);
    assign value   = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (insert)
        begin
            // shift up when the neighbor is also larger, else drop the new word here
            if (prev_greater)
                value_next = prev_value;
            else if (greater || at_end)
                value_next = in_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ===== design/ocr_divider.sv =====
// ----------------------------------------------------------------------------
// ocr_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ocr_divider #(
    parameter int NUM_W = 37,
    parameter int DEN_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic [NUM_W-1:0] quotient,
    output logic             done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg,  quo_next;
    logic [DEN_W-1:0] rem_reg,  rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
            den_reg <= divisor;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== design/overlap_cell_reduction.sv =====
// ----------------------------------------------------------------------------
// overlap_cell_reduction
// Reduces the overlapping source values of one output cell to one result.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                         word taken
//  in_ch    in   sample_value, sample_present, cell_last         valid & ready
//  out_ch   out  cell_result, result_valid, capacity_overflow    valid & ready
//  cfg_ch   in   reduce_mode                                     valid & ready
//
//  A non-last input word is taken in the collect state, and the sorted row of
//  cells inserts it as it is taken. A last word then passes the pick, calc and
//  send states plus the result wait; mean mode waits on the bit-serial divider.
//  Reset clears counts and accumulators; the value row needs no reset.
//  While a result waits on out_ch the input is held off; cfg_ch is always ready.
// ----------------------------------------------------------------------------
module overlap_cell_reduction
    import ocr_pkg::*;
#(
    parameter int MAX_SOURCES = MAX_SOURCES_DEF
) (
    input  logic clk,
    input  logic rst_n,
    ocr_in_if.sink    in_ch,
    ocr_out_if.source out_ch,
    ocr_cfg_if.sink   cfg_ch
);

    localparam int CNT_W = $clog2(MAX_SOURCES + 1);
    localparam int IDX_W = $clog2(MAX_SOURCES);
    localparam int SUM_W = VALUE_W + CNT_W;
    localparam int EXT_W = SUM_W + RESULT_W;
    localparam logic signed [EXT_W-1:0] RES_HI = EXT_W'({1'b0, {(RESULT_W-1){1'b1}}});
    localparam logic signed [EXT_W-1:0] RES_LO = -RES_HI - EXT_W'(1);

    state_t                     state_reg, state_next;
    mode_t                      mode_reg;
    logic [CNT_W-1:0]           count_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [VALUE_W-1:0]  min_reg, max_reg;
    logic                       ovf_seen_reg;
    logic signed [VALUE_W-1:0]  mid_lo_reg, mid_hi_reg;
    logic signed [RESULT_W-1:0] res_reg, res_next;
    logic                       rvalid_reg, ovf_reg;
    logic                       neg_reg;

    logic                       in_fire, out_fire, insert, load_out, div_start, div_done;
    logic                       have_any;
    logic [IDX_W-1:0]           idx_hi, idx_lo;
    logic signed [VALUE_W-1:0]  cell_val [MAX_SOURCES];
    logic                       cell_gt  [MAX_SOURCES];
    logic signed [VALUE_W:0]    mid_sum;
    logic [SUM_W-1:0]           sum_mag, quotient;
    logic signed [SUM_W-1:0]    mean_s;

    function automatic logic signed [RESULT_W-1:0] sat_res(input logic signed [SUM_W-1:0] v);
        logic signed [EXT_W-1:0] x;
        x = EXT_W'(v);
        if (x > RES_HI)
            return RES_HI[RESULT_W-1:0];
        else if (x < RES_LO)
            return RES_LO[RESULT_W-1:0];
        else
            return x[RESULT_W-1:0];
    endfunction

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign insert   = in_fire && in_ch.sample_present && (count_reg < CNT_W'(MAX_SOURCES));
    assign have_any = (count_reg != '0);
    assign cfg_ch.ready = 1'b1;

    // sorted row: each cell sees its left neighbor's value and compare
    for (genvar i = 0; i < MAX_SOURCES; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] pv;
        logic                      pg;
        if (i == 0)
        begin : g_first
            assign pv = '0;
            assign pg = 1'b0;
        end
        else
        begin : g_rest
            assign pv = cell_val[i-1];
            assign pg = cell_gt[i-1];
        end
        ocr_cell u_cell (
            .clk          (clk),
            .insert       (insert),
            .in_value     (in_ch.sample_value),
            .prev_value   (pv),
            .prev_greater (pg),
            .occupied     (CNT_W'(i) < count_reg),
            .at_end       (CNT_W'(i) == count_reg),
            .value        (cell_val[i]),
            .greater      (cell_gt[i])
        );
    end

    assign idx_hi = IDX_W'(count_reg >> 1);
    assign idx_lo = idx_hi - 1'b1;

    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign mean_s  = neg_reg ? -$signed(quotient) : $signed(quotient);

    ocr_divider #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (count_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_COLLECT:
                if (in_fire && in_ch.cell_last)
                    state_next = ST_PICK;
            ST_PICK:
                state_next = ST_CALC;
            ST_CALC:
                if (have_any && mode_reg == MODE_MEAN)
                    state_next = ST_DIV;
                else
                    state_next = ST_SEND;
            ST_DIV:
                if (div_done)
                    state_next = ST_SEND;
            ST_SEND:
                if (out_fire)
                    state_next = ST_COLLECT;
            default:
                state_next = ST_COLLECT;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ch.ready  = (state_reg == ST_COLLECT);
        out_ch.valid = (state_reg == ST_SEND);
        div_start    = (state_reg == ST_CALC) && have_any && (mode_reg == MODE_MEAN);
        load_out     = ((state_reg == ST_CALC) && !div_start) ||
                       ((state_reg == ST_DIV) && div_done);
    end

    assign mid_sum = (VALUE_W+1)'(mid_lo_reg) + (VALUE_W+1)'(mid_hi_reg);

    always_comb
    begin
        res_next = '0;
        if (state_reg == ST_DIV)
            res_next = sat_res(mean_s);
        else if (have_any)
        begin
            unique case (mode_reg)
                MODE_SUM:
                    res_next = sat_res(sum_reg);
                MODE_MIN:
                    res_next = RESULT_W'(min_reg);
                MODE_MAX:
                    res_next = RESULT_W'(max_reg);
                MODE_MEDIAN:
                    if (count_reg[0])
                        res_next = RESULT_W'(mid_hi_reg);
                    else
                        // halve toward zero
                        res_next = RESULT_W'($signed(mid_sum +
                                   (VALUE_W+1)'(mid_sum[VALUE_W])) >>> 1);
                default:
                    res_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_COLLECT;
            mode_reg     <= MODE_SUM;
            count_reg    <= '0;
            sum_reg      <= '0;
            min_reg      <= '0;
            max_reg      <= '0;
            ovf_seen_reg <= 1'b0;
            rvalid_reg   <= 1'b0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_ch.valid && cfg_ch.ready)
                mode_reg <= mode_t'(cfg_ch.reduce_mode);
            if (insert)
            begin
                count_reg <= count_reg + 1'b1;
                sum_reg   <= sum_reg + SUM_W'(in_ch.sample_value);
                if (!have_any || in_ch.sample_value < min_reg)
                    min_reg <= in_ch.sample_value;
                if (!have_any || in_ch.sample_value > max_reg)
                    max_reg <= in_ch.sample_value;
            end
            else if (in_fire && in_ch.sample_present)
                ovf_seen_reg <= 1'b1;
            if (load_out)
            begin
                rvalid_reg <= have_any;
                ovf_reg    <= have_any && ovf_seen_reg;
            end
            // clear for the next cell once the result word is taken
            if (out_fire)
            begin
                count_reg    <= '0;
                sum_reg      <= '0;
                min_reg      <= '0;
                max_reg      <= '0;
                ovf_seen_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PICK)
        begin
            mid_hi_reg <= cell_val[idx_hi];
            mid_lo_reg <= cell_val[idx_lo];
        end
        if (div_start)
            neg_reg <= sum_reg[SUM_W-1];
        if (load_out)
            res_reg <= res_next;
    end

    assign out_ch.cell_result       = res_reg;
    assign out_ch.result_valid      = rvalid_reg;
    assign out_ch.capacity_overflow = ovf_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SOURCES))
        else $error("present count above capacity");

    a_div_only_in_mean: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside mean wait");

    a_missing_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.result_valid) |->
            (out_ch.cell_result == '0 && !out_ch.capacity_overflow))
        else $error("missing cell with nonzero result");

    a_clear_after_send: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |=> count_reg == '0 && !ovf_seen_reg)
        else $error("accumulators not cleared after result");

endmodule
